[src/grcr_pkg.sv]
// Shared types, constants and stencil tables for the grid ray-cast range core.
// Used by grcr_ctrl, grcr_datapath and grid_ray_cast_range_core.
package grcr_pkg;

  localparam int unsigned DEF_MAX_ROWS = 256;
  localparam int unsigned DEF_MAX_COLS = 256;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_DATA_W-1:0] RESET_ROWS = 9'd256;
  localparam logic [CFG_DATA_W-1:0] RESET_COLS = 9'd256;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam int unsigned CNT_W       = 5;
  localparam logic [CNT_W-1:0] SQRT_LAST  = 5'd26;
  localparam logic [CNT_W-1:0] DIV_LAST   = 5'd17;
  localparam logic [2:0] STENCIL_LAST = 3'd5;
  localparam logic [17:0] UNIT_ONE    = 18'd65536;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_DIVX_INIT,
    S_DIVX,
    S_DIVY_INIT,
    S_DIVY,
    S_MARCH_INIT,
    S_ROUND,
    S_PROBE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       cell_wr;
    logic       load;
    logic       sq_x;
    logic       sq_y;
    logic       sqrt_step;
    logic       div_init;
    logic       div_sel;
    logic       div_step;
    logic       march_init;
    logic       round;
    logic       probe;
    logic [2:0] probe_k;
    logic       advance;
    logic       res_same;
    logic       res_hit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pts_same;
    logic maxr_zero;
    logic any_in;
    logic occ;
    logic last_step;
  } sts_t;

  // Plus-shaped stencil: left, center, up, down, right
  function automatic logic signed [1:0] stencil_dx(input logic [2:0] k);
    logic signed [1:0] v;
    case (k)
      3'd0:    v = -2'sd1;
      3'd4:    v = 2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] stencil_dy(input logic [2:0] k);
    logic signed [1:0] v;
    case (k)
      3'd2:    v = 2'sd1;
      3'd3:    v = -2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

[src/grcr_ctrl.sv]
// Sequencer for the grid ray-cast range core: clear pass, square root,
// division and march steps. Depends on grcr_pkg.
module grcr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            command_i,
  input  grcr_pkg::sts_t  sts_i,
  output grcr_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            result_valid_o
);

  grcr_pkg::state_e state_q, state_d;
  logic [grcr_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grcr_pkg::S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.probe_k  = cnt_q[2:0];
    busy           = (state_q != grcr_pkg::S_IDLE);
    result_valid_o = 1'b0;
    case (state_q)
      grcr_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = grcr_pkg::S_IDLE;
      end
      grcr_pkg::S_IDLE: begin
        if (start) begin
          if (command_i == grcr_pkg::CMD_CAST) begin
            cmd_o.load = 1'b1;
            state_d    = grcr_pkg::S_SQX;
          end else begin
            cmd_o.cell_wr = 1'b1;
          end
        end
      end
      grcr_pkg::S_SQX: begin
        if (sts_i.pts_same) begin
          cmd_o.res_same = 1'b1;
          state_d        = grcr_pkg::S_DONE;
        end else begin
          cmd_o.sq_x = 1'b1;
          state_d    = grcr_pkg::S_SQY;
        end
      end
      grcr_pkg::S_SQY: begin
        cmd_o.sq_y = 1'b1;
        cnt_d      = '0;
        state_d    = grcr_pkg::S_SQRT;
      end
      grcr_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == grcr_pkg::SQRT_LAST) state_d = grcr_pkg::S_DIVX_INIT;
      end
      grcr_pkg::S_DIVX_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = grcr_pkg::S_DIVX;
      end
      grcr_pkg::S_DIVX: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == grcr_pkg::DIV_LAST) state_d = grcr_pkg::S_DIVY_INIT;
      end
      grcr_pkg::S_DIVY_INIT: begin
        // store ux and start on uy
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel  = 1'b1;
        cnt_d          = '0;
        state_d        = grcr_pkg::S_DIVY;
      end
      grcr_pkg::S_DIVY: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == grcr_pkg::DIV_LAST) state_d = grcr_pkg::S_MARCH_INIT;
      end
      grcr_pkg::S_MARCH_INIT: begin
        cmd_o.march_init = 1'b1;
        state_d = sts_i.maxr_zero ? grcr_pkg::S_DONE : grcr_pkg::S_ROUND;
      end
      grcr_pkg::S_ROUND: begin
        cmd_o.round = 1'b1;
        cnt_d       = '0;
        state_d     = grcr_pkg::S_PROBE;
      end
      grcr_pkg::S_PROBE: begin
        cmd_o.probe = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q[2:0] == grcr_pkg::STENCIL_LAST) begin
          if (!sts_i.any_in) begin
            state_d = grcr_pkg::S_DONE;
          end else if (sts_i.occ) begin
            cmd_o.res_hit = 1'b1;
            state_d       = grcr_pkg::S_DONE;
          end else if (sts_i.last_step) begin
            state_d = grcr_pkg::S_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = grcr_pkg::S_ROUND;
          end
        end
      end
      grcr_pkg::S_DONE: begin
        result_valid_o = 1'b1;
        state_d        = grcr_pkg::S_IDLE;
      end
      default: state_d = grcr_pkg::S_IDLE;
    endcase
  end

endmodule

[src/grcr_datapath.sv]
// Datapath of the grid ray-cast range core: occupancy memory, config
// registers, iterative square root and divider, march point. Uses grcr_pkg.
module grcr_datapath #(
  parameter int unsigned MAX_ROWS = grcr_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = grcr_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [grcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grcr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [7:0]                    cell_row_i,
  input  logic [7:0]                    cell_col_i,
  input  logic                          cell_occupied_i,
  input  logic signed [17:0]            robot_x_i,
  input  logic signed [17:0]            robot_y_i,
  input  logic signed [17:0]            landmark_x_i,
  input  logic signed [17:0]            landmark_y_i,
  input  grcr_pkg::cmd_t                cmd_i,
  output grcr_pkg::sts_t                sts_o,
  output logic                          hit_o,
  output logic [8:0]                    range_steps_o
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RCW   = $clog2(MAX_ROWS + MAX_COLS + 1);

  // configuration
  logic [grcr_pkg::CFG_DATA_W-1:0] rows_cfg_q, cols_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= grcr_pkg::RESET_ROWS;
      cols_cfg_q <= grcr_pkg::RESET_COLS;
    end else if (cfg_we_i) begin
      if (cfg_index_i == grcr_pkg::REG_ROWS) rows_cfg_q <= cfg_wdata_i;
      if (cfg_index_i == grcr_pkg::REG_COLS) cols_cfg_q <= cfg_wdata_i;
    end
  end

  // occupancy memory and clear pass
  logic mem [CELLS];
  logic [AW-1:0] clr_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [31:0]   cell_addr;
  logic          cell_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear) clr_q <= clr_q + 1'b1;
  end

  assign cell_in_range = (32'(cell_row_i) < MAX_ROWS) && (32'(cell_col_i) < MAX_COLS);
  assign cell_addr     = 32'(cell_row_i) * MAX_COLS + 32'(cell_col_i);
  assign we    = cmd_i.clear || (cmd_i.cell_wr && cell_in_range);
  assign waddr = cmd_i.clear ? clr_q : AW'(cell_addr);
  assign wdata = cmd_i.clear ? 1'b0 : cell_occupied_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  // operands of the cast
  logic signed [17:0] rx_q, ry_q;
  logic signed [18:0] dx_q, dy_q;
  logic [RCW-1:0]     rows_q, cols_q, maxr, r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rx_q   <= robot_x_i;
      ry_q   <= robot_y_i;
      dx_q   <= {landmark_x_i[17], landmark_x_i} - {robot_x_i[17], robot_x_i};
      dy_q   <= {landmark_y_i[17], landmark_y_i} - {robot_y_i[17], robot_y_i};
      rows_q <= (32'(rows_cfg_q) < MAX_ROWS) ? RCW'(rows_cfg_q) : RCW'(MAX_ROWS);
      cols_q <= (32'(cols_cfg_q) < MAX_COLS) ? RCW'(cols_cfg_q) : RCW'(MAX_COLS);
    end
  end

  assign maxr = rows_q + cols_q;

  // squares and integer square root
  logic signed [37:0] sq;
  logic [37:0] prod_q;
  logic [53:0] v_q, res_q, bit_q, trial;

  assign sq    = cmd_i.sq_x ? dx_q * dx_q : dy_q * dy_q;
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x) prod_q <= unsigned'(sq);
    if (cmd_i.sq_y) begin
      v_q   <= {prod_q + unsigned'(sq), 16'b0};
      res_q <= '0;
      bit_q <= 54'd1 << 52;
    end else if (cmd_i.sqrt_step) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // restoring divider for the unit vector, one quotient bit a step
  logic [27:0]        m;
  logic [18:0]        div_num;
  logic [45:0]        rem_q, dv_q;
  logic [17:0]        quo_q, quo_sat;
  logic signed [17:0] ux_q, uy_q, u_new;
  logic               u_neg;

  assign m       = res_q[27:0];
  assign div_num = cmd_i.div_sel ? (dy_q[18] ? -dy_q : dy_q) : (dx_q[18] ? -dx_q : dx_q);
  assign quo_sat = (quo_q > grcr_pkg::UNIT_ONE) ? grcr_pkg::UNIT_ONE : quo_q;
  assign u_neg   = cmd_i.march_init ? dy_q[18] : dx_q[18];
  assign u_new   = u_neg ? -signed'(quo_sat) : signed'(quo_sat);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= (46'(div_num) << 24) + 46'(m >> 1);
      dv_q  <= 46'(m) << 17;
      quo_q <= '0;
      if (cmd_i.div_sel) ux_q <= u_new;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dv_q) begin
        rem_q <= rem_q - dv_q;
        quo_q <= {quo_q[16:0], 1'b1};
      end else begin
        quo_q <= {quo_q[16:0], 1'b0};
      end
      dv_q <= dv_q >> 1;
    end
    if (cmd_i.march_init) uy_q <= u_new;
  end

  // march point in Q.16 and its rounded cell
  logic signed [33:0] px_q, py_q;
  logic [33:0]        ax, ay;
  logic [17:0]        qx, qy;
  logic signed [19:0] tx_q, ty_q;

  assign ax = px_q[33] ? 34'(-px_q) : 34'(px_q);
  assign ay = py_q[33] ? 34'(-py_q) : 34'(py_q);
  assign qx = 18'((ax + 34'd32768) >> 16);
  assign qy = 18'((ay + 34'd32768) >> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.march_init) begin
      px_q <= {{8{rx_q[17]}}, rx_q, 8'b0};
      py_q <= {{8{ry_q[17]}}, ry_q, 8'b0};
    end else if (cmd_i.advance) begin
      px_q <= px_q + {{16{ux_q[17]}}, ux_q};
      py_q <= py_q + {{16{uy_q[17]}}, uy_q};
    end
    if (cmd_i.round) begin
      tx_q <= px_q[33] ? -signed'({2'b0, qx}) : signed'({2'b0, qx});
      ty_q <= py_q[33] ? -signed'({2'b0, qy}) : signed'({2'b0, qy});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r_q <= '0;
    else if (cmd_i.march_init) r_q <= '0;
    else if (cmd_i.advance) r_q <= r_q + 1'b1;
  end

  // stencil probe: issue one read a cycle, check the previous one
  logic signed [20:0] cx, cy;
  logic               inb, issue;
  logic [31:0]        probe_addr;
  logic [AW-1:0]      raddr;
  logic               rdata_q, inb_q, occ_q, any_q;

  assign cx = {tx_q[19], tx_q} + 21'(grcr_pkg::stencil_dx(cmd_i.probe_k));
  assign cy = {ty_q[19], ty_q} + 21'(grcr_pkg::stencil_dy(cmd_i.probe_k));
  assign inb = !cx[20] && !cy[20]
            && (cx < signed'(21'(cols_q))) && (cy < signed'(21'(rows_q)));
  assign probe_addr = 32'(cy[19:0]) * MAX_COLS + 32'(cx[19:0]);
  assign raddr = inb ? AW'(probe_addr) : '0;
  assign issue = cmd_i.probe && (cmd_i.probe_k != grcr_pkg::STENCIL_LAST);

  always_ff @(posedge clk_i) begin
    if (issue) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inb_q <= 1'b0;
      occ_q <= 1'b0;
      any_q <= 1'b0;
    end else if (cmd_i.round) begin
      inb_q <= 1'b0;
      occ_q <= 1'b0;
      any_q <= 1'b0;
    end else if (cmd_i.probe) begin
      occ_q <= occ_q | (inb_q & rdata_q);
      inb_q <= issue & inb;
      any_q <= any_q | (issue & inb);
    end
  end

  // result
  logic       hit_q;
  logic [8:0] range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      range_q <= '0;
    end else if (cmd_i.load) begin
      hit_q   <= 1'b0;
      range_q <= '0;
    end else if (cmd_i.res_same) begin
      hit_q <= 1'b1;
    end else if (cmd_i.res_hit) begin
      hit_q   <= 1'b1;
      range_q <= 9'(r_q);
    end
  end

  assign hit_o         = hit_q;
  assign range_steps_o = range_q;

  assign sts_o.clr_last  = (clr_q == AW'(CELLS - 1));
  assign sts_o.pts_same  = (dx_q == '0) && (dy_q == '0);
  assign sts_o.maxr_zero = (maxr == '0);
  assign sts_o.any_in    = any_q;
  assign sts_o.occ       = occ_q | (inb_q & rdata_q);
  assign sts_o.last_step = (r_q == maxr - 1'b1);

endmodule

[src/grid_ray_cast_range_core.sv]
// Top level of the grid ray-cast range core.
// Instantiates grcr_ctrl and grcr_datapath; uses grcr_pkg.
//
// Usage:
//   Issue a command by raising start while busy is low; it is taken at that
//   clock edge. command_i = write stores cell_occupied_i at
//   (cell_row_i, cell_col_i) in that same cycle and gives no result; busy
//   stays low, so writes can follow every cycle.
//   command_i = cast marches from the robot to the landmark and returns one
//   item: result_valid_o is high for exactly one cycle with hit_o and
//   range_steps_o. The receiver cannot stall; take the item in that cycle.
//   Each march step rounds the point, then makes the five stencil reads
//   through the single memory read port; a cast makes at most rows + cols
//   steps after a 27-step square root and two 18-step divisions. Casts do
//   not overlap: the next command waits until busy falls.
//   Reset: configuration returns to 256 rows and 256 columns, then a
//   clearing pass through the MAX_ROWS*MAX_COLS cells (65536 by default) frees
//   every cell while busy is high. cfg_we_i writes are taken at any time.
module grid_ray_cast_range_core #(
  parameter int unsigned MAX_ROWS = grcr_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = grcr_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [grcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grcr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [7:0]                    cell_row_i,
  input  logic [7:0]                    cell_col_i,
  input  logic                          cell_occupied_i,
  input  logic signed [17:0]            robot_x_i,
  input  logic signed [17:0]            robot_y_i,
  input  logic signed [17:0]            landmark_x_i,
  input  logic signed [17:0]            landmark_y_i,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic [8:0]                    range_steps_o
);

  grcr_pkg::cmd_t cmd;
  grcr_pkg::sts_t sts;

  grcr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .command_i      (command_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  grcr_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .cell_occupied_i (cell_occupied_i),
    .robot_x_i       (robot_x_i),
    .robot_y_i       (robot_y_i),
    .landmark_x_i    (landmark_x_i),
    .landmark_y_i    (landmark_y_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .hit_o           (hit_o),
    .range_steps_o   (range_steps_o)
  );

  // one result per cast, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // an accepted cast keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == grcr_pkg::CMD_CAST)) |=> busy)
    else $error("cast accepted without going busy");

  // a miss reports range zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (range_steps_o == '0))
    else $error("miss with nonzero range");

  // the result strobe only ends a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside a cast");

endmodule

[verif/grid_ray_cast_range_core_test.sv]
// Self-checking testbench for grid_ray_cast_range_core: directed and random cell writes and
// ray casts, checked against an in-bench predictor. Depends on grcr_pkg.
`timescale 1ns / 100ps

module grid_ray_cast_range_core_test;

  localparam logic [grcr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [grcr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned GRID_DIM   = 256;
  localparam int unsigned STALL_LIMIT = 300000;

  typedef struct packed {
    logic       hit;
    logic [8:0] steps;
  } cast_result_t;

  class range_scoreboard;
    bit           occ_grid[GRID_DIM*GRID_DIM];
    logic [8:0]   rows_reg = grcr_pkg::RESET_ROWS;
    logic [8:0]   cols_reg = grcr_pkg::RESET_COLS;
    cast_result_t pending_q[$];
    int           mismatches;
    int           casts_seen;
    int           hits_seen;

    function void set_reg(logic [grcr_pkg::CFG_IDX_W-1:0] idx, logic [8:0] val);
      if (idx == grcr_pkg::REG_ROWS) rows_reg = val;
      else if (idx == grcr_pkg::REG_COLS) cols_reg = val;
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // nearest, ties away from zero
    function longint quot_round(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint unit_of(longint d, longint unsigned mag);
      longint u;
      u = quot_round(d * (longint'(1) << 24), mag);
      if (u > 65536) u = 65536;
      if (u < -65536) u = -65536;
      return u;
    endfunction

    function cast_result_t cast_ray(longint rx, longint ry, longint lx, longint ly);
      cast_result_t res;
      longint dx, dy, ux, uy, rows, cols, tx, ty, cx, cy;
      longint unsigned mag;
      int nin;
      bit occ;
      res = '0;
      dx = lx - rx;
      dy = ly - ry;
      if (dx == 0 && dy == 0) begin
        res.hit = 1'b1;
        return res;
      end
      mag = sqrt_floor(longint'(dx * dx + dy * dy) << 16);
      ux = unit_of(dx, mag);
      uy = unit_of(dy, mag);
      rows = (rows_reg < GRID_DIM) ? rows_reg : GRID_DIM;
      cols = (cols_reg < GRID_DIM) ? cols_reg : GRID_DIM;
      for (longint r = 0; r < rows + cols; r++) begin
        tx = quot_round(rx * 256 + ux * r, 65536);
        ty = quot_round(ry * 256 + uy * r, 65536);
        nin = 0;
        occ = 0;
        for (int k = 0; k < 5; k++) begin
          cx = tx + ((k == 0) ? -1 : (k == 4) ? 1 : 0);
          cy = ty + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
          if (cx < 0 || cx >= cols || cy < 0 || cy >= rows) continue;
          nin++;
          if (occ_grid[cy * GRID_DIM + cx]) occ = 1;
        end
        if (nin == 0) break;
        if (occ) begin
          res.hit = 1'b1;
          res.steps = r[8:0];
          break;
        end
      end
      return res;
    endfunction

    function void note_item(logic cmd, logic [7:0] row, logic [7:0] col, logic occ,
                            logic signed [17:0] rx, logic signed [17:0] ry,
                            logic signed [17:0] lx, logic signed [17:0] ly);
      if (cmd == grcr_pkg::CMD_WRITE) begin
        occ_grid[row * GRID_DIM + col] = occ;
      end else begin
        pending_q.push_back(cast_ray(rx, ry, lx, ly));
      end
    endfunction

    function void check_result(logic hit, logic [8:0] steps);
      cast_result_t want;
      casts_seen++;
      if (hit) hits_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result hit=%0b steps=%0d", hit, steps);
        return;
      end
      want = pending_q.pop_front();
      if (want.hit !== hit || want.steps !== steps) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch: expected hit=%0b steps=%0d, got hit=%0b steps=%0d",
                   want.hit, want.steps, hit, steps);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [grcr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [grcr_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic start, busy;
  logic command_i, cell_occupied_i;
  logic [7:0] cell_row_i, cell_col_i;
  logic signed [17:0] robot_x_i, robot_y_i, landmark_x_i, landmark_y_i;
  logic result_valid_o, hit_o;
  logic [8:0] range_steps_o;

  range_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;

  grid_ray_cast_range_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .start, .busy,
    .command_i, .cell_row_i, .cell_col_i, .cell_occupied_i,
    .robot_x_i, .robot_y_i, .landmark_x_i, .landmark_y_i,
    .result_valid_o, .hit_o, .range_steps_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_item(command_i, cell_row_i, cell_col_i, cell_occupied_i,
                   robot_x_i, robot_y_i, landmark_x_i, landmark_y_i);
    if (rst_ni && result_valid_o) sb.check_result(hit_o, range_steps_o);
  end

  // Count cycles with no progress; bail out on a hang
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [7:0] row, logic [7:0] col, logic occ,
                           logic signed [17:0] rx, logic signed [17:0] ry,
                           logic signed [17:0] lx, logic signed [17:0] ly);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    command_i       <= cmd;
    cell_row_i      <= row;
    cell_col_i      <= col;
    cell_occupied_i <= occ;
    robot_x_i       <= rx;
    robot_y_i       <= ry;
    landmark_x_i    <= lx;
    landmark_y_i    <= ly;
    start           <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold start low until every cast has answered and the core is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [grcr_pkg::CFG_IDX_W-1:0] idx, logic [8:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_cell(int row, int col, logic occ);
    send_item(grcr_pkg::CMD_WRITE, row[7:0], col[7:0], occ,
              18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
  endtask

  task automatic cast(int rx, int ry, int lx, int ly);
    send_item(grcr_pkg::CMD_CAST, 8'($urandom), 8'($urandom), 1'($urandom),
              rx[17:0], ry[17:0], lx[17:0], ly[17:0]);
  endtask

  // Mostly coordinates near the grid in use, sometimes anything
  function automatic int pick_coord(int span);
    if ($urandom_range(9) == 0) return $signed(18'($urandom));
    return $urandom_range(0, span + 16) * 256 - 8 * 256 + $urandom_range(0, 255);
  endfunction

  task automatic random_phase(int n, int span);
    int rx, ry;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(1)) write_cell($urandom_range(0, span), $urandom_range(0, span),
                                          $urandom_range(99) < 70);
        else write_cell($urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
      end else begin
        rx = pick_coord(span);
        ry = pick_coord(span);
        if ($urandom_range(19) == 0) cast(rx, ry, rx, ry);
        else cast(rx, ry, pick_coord(span), pick_coord(span));
      end
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = grcr_pkg::REG_ROWS;
    cfg_wdata_i     = '0;
    start           = 1'b0;
    command_i       = grcr_pkg::CMD_WRITE;
    cell_row_i      = '0;
    cell_col_i      = '0;
    cell_occupied_i = 1'b0;
    robot_x_i       = '0;
    robot_y_i       = '0;
    landmark_x_i    = '0;
    landmark_y_i    = '0;
    quiet_cycles    = 0;
    idle_pct        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, identical points, extremes, clear after set
    write_cell(0, 0, 1'b1);
    write_cell(255, 255, 1'b1);
    write_cell(10, 40, 1'b1);
    cast(0, 0, 0, 0);
    cast(-131072, 131071, -131072, 131071);
    cast(20 * 256, 10 * 256, 60 * 256, 10 * 256);
    cast(250 * 256, 250 * 256, 260 * 256, 260 * 256);
    cast(-131072, -131072, 131071, 131071);
    cast(131071, -131072, -131072, 131071);
    cast(5 * 256 + 128, 5 * 256 + 128, 5 * 256 + 129, 5 * 256 + 128);
    write_cell(10, 40, 1'b0);
    cast(20 * 256, 10 * 256, 60 * 256, 10 * 256);
    cast(100 * 256, 100 * 256, 100 * 256, -131072);
    write_cell(255, 255, 1'b0);
    write_cell(0, 0, 1'b0);
    cast(-131072, -131072, -131071, -131072);

    idle_pct = 0;
    random_phase(40, 255);

    write_reg(grcr_pkg::REG_ROWS, 9'd20);
    write_reg(grcr_pkg::REG_COLS, 9'd30);
    idle_pct = 47;
    random_phase(45, 30);

    write_reg(grcr_pkg::REG_ROWS, 9'd0);
    write_reg(grcr_pkg::REG_COLS, 9'd511);
    write_reg(REG_SPARE_A, 9'd7);
    write_reg(REG_SPARE_B, 9'd1);
    idle_pct = 11;
    random_phase(25, 255);

    write_reg(grcr_pkg::REG_ROWS, 9'd511);
    write_reg(grcr_pkg::REG_COLS, 9'd1);
    idle_pct = 47;
    random_phase(40, 255);

    write_reg(grcr_pkg::REG_ROWS, 9'd256);
    write_reg(grcr_pkg::REG_COLS, 9'd256);
    idle_pct = 11;
    random_phase(60, 255);

    drain();
    repeat (50) @(posedge clk_i);
    $display("Run covered %0d casts (%0d hits) over five register settings, %0d mismatches.",
             sb.casts_seen, sb.hits_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
